[rtl/bdto_pkg.sv]
// Shared types, codes and the binary-to-BCD step for the decimal text output unit.
package bdto_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_SEL_W = $clog2(NUM_DIGITS);
  localparam int unsigned BCD_W = 4 * NUM_DIGITS;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned CONV_STEPS = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W = $clog2(CONV_STEPS);

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [VALUE_W-1:0] TWO_DIGIT_MAX = 32'd99;
  localparam logic [VALUE_W-1:0] THREE_DIGIT_MAX = 32'd999;

  // First (highest) digit index written for each number format (digits go out MS first).
  localparam logic [DIGIT_SEL_W-1:0] TOP_DIG_TWO = 4'd1;
  localparam logic [DIGIT_SEL_W-1:0] TOP_DIG_THREE = 4'd2;
  localparam logic [DIGIT_SEL_W-1:0] TOP_DIG_TEN = 4'd9;

  localparam logic [2:0] MODE_BYTE = 3'd0;
  localparam logic [2:0] MODE_NUM2 = 3'd1;
  localparam logic [2:0] MODE_NUM3 = 3'd2;
  localparam logic [2:0] MODE_NUM10 = 3'd3;
  localparam logic [2:0] MODE_SEND = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE,
    ST_SEND
  } bdto_state_t;

  typedef struct packed {
    logic                   load_value;
    logic                   conv_step;
    logic                   wr_raw;
    logic                   wr_digit;
    logic [DIGIT_SEL_W-1:0] digit_sel;
    logic                   rd_send;
    logic                   load_out;
    logic                   clr_idx;
  } bdto_cmd_t;

  typedef struct packed {
    logic send_avail;
    logic out_free;
    logic le_two;
    logic le_three;
  } bdto_stat_t;

  // Four shift-and-add-3 iterations of double dabble on {bcd, bin}.
  function automatic logic [BCD_W+VALUE_W-1:0] dd_step(input logic [BCD_W+VALUE_W-1:0] s);
    logic [BCD_W+VALUE_W-1:0] t;
    t = s;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (t[VALUE_W + 4*d +: 4] >= 4'd5) begin
          t[VALUE_W + 4*d +: 4] = t[VALUE_W + 4*d +: 4] + 4'd3;
        end
      end
      t = {t[BCD_W+VALUE_W-2:0], 1'b0};
    end
    return t;
  endfunction

endpackage

[rtl/bdto_ctrl.sv]
// Sequencer: decodes items and steps conversion, digit writes and sends.
module bdto_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          in_mode,
  input  bdto_pkg::bdto_stat_t stat,
  output bdto_pkg::bdto_cmd_t  cmd
);
  import bdto_pkg::*;

  bdto_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIGIT_SEL_W-1:0] dig_r, dig_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dig_r   <= dig_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dig_nxt   = dig_r;
    cmd       = '0;
    cmd.digit_sel = dig_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_mode)
            MODE_BYTE: cmd.wr_raw = 1'b1;
            MODE_NUM2: begin
              if (stat.le_two) begin
                cmd.load_value = 1'b1;
                step_nxt  = '0;
                dig_nxt   = TOP_DIG_TWO;
                state_nxt = ST_CONV;
              end
            end
            MODE_NUM3: begin
              if (stat.le_three) begin
                cmd.load_value = 1'b1;
                step_nxt  = '0;
                dig_nxt   = TOP_DIG_THREE;
                state_nxt = ST_CONV;
              end
            end
            MODE_NUM10: begin
              cmd.load_value = 1'b1;
              step_nxt  = '0;
              dig_nxt   = TOP_DIG_TEN;
              state_nxt = ST_CONV;
            end
            MODE_SEND: begin
              if (stat.send_avail) begin
                cmd.rd_send = 1'b1;
                state_nxt   = ST_SEND;
              end else begin
                cmd.clr_idx = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CONV_STEPS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_digit = 1'b1;
        if (dig_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          dig_nxt = dig_r - 1'b1;
        end
      end
      ST_SEND: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_conv_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |=> state_r == ST_CONV || state_r == ST_WRITE)
    else $error("conversion left to an unexpected state");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_raw, cmd.wr_digit, cmd.rd_send, cmd.clr_idx}))
    else $error("store write and send issued together");

  a_write_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE && dig_r == '0 |=> state_r == ST_IDLE)
    else $error("digit writes did not end after the lowest digit");

endmodule

[rtl/bdto_dp.sv]
// Datapath: BCD converter, text store, fill/send indices and output register.
module bdto_dp #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           in_value,
  input  bdto_pkg::bdto_cmd_t   cmd,
  output bdto_pkg::bdto_stat_t  stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);
  import bdto_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned IW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0] store_r [BUFFER_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_last_r, rd_last_nxt;

  logic [IW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] send_r, send_nxt;
  logic [IW-1:0] send_inc;

  logic [BCD_W+VALUE_W-1:0] conv_r, conv_nxt;
  logic [3:0] digit;
  logic [7:0] wr_data;
  logic       wr_en;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_last_r;

  assign digit   = conv_r[VALUE_W + 4*cmd.digit_sel +: 4];
  assign wr_data = cmd.wr_raw ? in_value[7:0] : (ASCII_ZERO + {4'd0, digit});
  assign wr_en   = (cmd.wr_raw || cmd.wr_digit) && (fill_r < IW'(BUFFER_DEPTH));
  assign send_inc = send_r + 1'b1;

  assign stat.send_avail = send_r < fill_r;
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.le_two     = in_value <= TWO_DIGIT_MAX;
  assign stat.le_three   = in_value <= THREE_DIGIT_MAX;

  always_comb begin
    fill_nxt    = fill_r;
    send_nxt    = send_r;
    rd_last_nxt = rd_last_r;
    if (wr_en) begin
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.rd_send) begin
      rd_last_nxt = send_inc >= fill_r;
      if (send_inc >= fill_r) begin
        send_nxt = '0;
        fill_nxt = '0;
      end else begin
        send_nxt = send_inc;
      end
    end
    if (cmd.clr_idx) begin
      send_nxt = '0;
      fill_nxt = '0;
    end
  end

  always_comb begin
    conv_nxt = conv_r;
    if (cmd.load_value) begin
      conv_nxt = {{BCD_W{1'b0}}, in_value};
    end else if (cmd.conv_step) begin
      conv_nxt = dd_step(conv_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      send_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      send_r      <= send_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conv_r    <= conv_nxt;
    rd_last_r <= rd_last_nxt;
    if (cmd.load_out) begin
      out_data_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  // text store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[fill_r[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_send) begin
      rd_data_r <= store_r[send_r[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (send_r < fill_r) || (send_r == '0 && fill_r == '0))
    else $error("send index ran past fill index");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= IW'(BUFFER_DEPTH))
    else $error("fill index beyond store depth");

  a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fill_r >= $past(fill_r)) || (fill_r == '0))
    else $error("fill index dropped without a reset to zero");

endmodule

[rtl/buffered_decimal_text_output_unit.sv]
// Sequence: a raw byte is stored in the accept cycle; a number runs the conversion
// steps, then writes its digits MS first, before the next input word is taken.
// A send word reads the store into the read register and loads it into the output
// register once free; the next word is taken while that result waits to be drained.
// Reset (rst_n low, synchronous) empties the store indices and the output register;
// store contents are not cleared and no clearing pass runs.
module buffered_decimal_text_output_unit #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast   // last_of_run
);
  import bdto_pkg::*;

  bdto_cmd_t  cmd;
  bdto_stat_t stat;

  bdto_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdto_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
